>>> design/ssrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssrq_pkg;

    localparam int CAPACITY  = 16;
    localparam int POS_W     = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CMD_W     = 3;
    localparam int SLOT_IN_W = 4;
    localparam int OCC_W     = 5;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 3'd0,
        CMD_COMMIT  = 3'd1,
        CMD_CLAIM   = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic                 full_res;
        logic                 empty_res;
        logic [OCC_W-1:0]     occupancy;
        logic [SLOT_IN_W-1:0] slot_out;
        logic                 ok;
    } result_t;

endpackage
`default_nettype wire

>>> design/sequenced_slot_ring_queue.sv
// Sequenced slot ring queue control.
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless the result is stalled; in the stage between the
// registers, commit/release update one slot sequence, reserve/claim one position, clear all.
// Reset (aresetn low, synchronous): positions cleared, slot i sequence = i, no items held.
`timescale 1ns / 1ps
`default_nettype none
module sequenced_slot_ring_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] cmd, [6:3] slot_in, [7] zero
    input  wire logic [ssrq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] ok, [4:1] slot_out, [9:5] occupancy, [10] empty_res, [11] full_res, [15:12] zero
    output logic [ssrq_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int PW = ssrq_pkg::POS_W;
    localparam int SW = ssrq_pkg::SLOT_W;
    localparam int RW = $bits(ssrq_pkg::result_t);

    logic                                in_valid_reg;
    logic [ssrq_pkg::CMD_W-1:0]          cmd_reg;
    logic [ssrq_pkg::SLOT_IN_W-1:0]      slot_in_reg;

    logic                                out_valid_reg;
    ssrq_pkg::result_t                   res_reg;
    ssrq_pkg::result_t                   res_next;

    logic [PW-1:0]                       tail_reg, tail_next;
    logic [PW-1:0]                       head_reg, head_next;
    logic [PW-1:0]                       seq_reg [ssrq_pkg::CAPACITY];

    logic                                fire;
    logic [SW-1:0]                       addr;
    logic [PW-1:0]                       seq_rd;
    logic                                seq_we;
    logic [PW-1:0]                       seq_wdata;
    logic                                clear;
    logic [PW-1:0]                       diff;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ssrq_pkg::M_TDATA_W - RW){1'b0}}, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg     <= s_axis_tdata[ssrq_pkg::CMD_W-1:0];
            slot_in_reg <= s_axis_tdata[ssrq_pkg::CMD_W +: ssrq_pkg::SLOT_IN_W];
        end
    end

    always_comb begin
        case (cmd_reg)
            ssrq_pkg::CMD_RESERVE: addr = tail_reg[SW-1:0];
            ssrq_pkg::CMD_CLAIM:   addr = head_reg[SW-1:0];
            default:               addr = slot_in_reg[SW-1:0];
        endcase
    end

    assign seq_rd = seq_reg[addr];

    always_comb begin
        tail_next = tail_reg;
        head_next = head_reg;
        seq_we    = 1'b0;
        seq_wdata = seq_rd;
        clear     = 1'b0;
        res_next  = '0;
        case (cmd_reg)
            ssrq_pkg::CMD_RESERVE: begin
                if (seq_rd == tail_reg) begin
                    tail_next         = tail_reg + PW'(1);
                    res_next.ok       = 1'b1;
                    res_next.slot_out = ssrq_pkg::SLOT_IN_W'(addr);
                end
            end
            ssrq_pkg::CMD_COMMIT: begin
                seq_we      = 1'b1;
                seq_wdata   = seq_rd + PW'(1);
                res_next.ok = 1'b1;
            end
            ssrq_pkg::CMD_CLAIM: begin
                if (seq_rd == head_reg + PW'(1)) begin
                    head_next         = head_reg + PW'(1);
                    res_next.ok       = 1'b1;
                    res_next.slot_out = ssrq_pkg::SLOT_IN_W'(addr);
                end
            end
            ssrq_pkg::CMD_RELEASE: begin
                seq_we      = 1'b1;
                seq_wdata   = seq_rd + PW'(ssrq_pkg::CAPACITY - 1);
                res_next.ok = 1'b1;
            end
            ssrq_pkg::CMD_CLEAR: begin
                clear       = 1'b1;
                tail_next   = '0;
                head_next   = '0;
                res_next.ok = 1'b1;
            end
            default: begin
            end
        endcase
        diff               = tail_next - head_next;
        res_next.empty_res = (diff == '0);
        res_next.full_res  = (diff >= PW'(ssrq_pkg::CAPACITY));
        res_next.occupancy = res_next.full_res ? ssrq_pkg::OCC_W'(ssrq_pkg::CAPACITY)
                                               : diff[ssrq_pkg::OCC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg <= '0;
            head_reg <= '0;
            for (int i = 0; i < ssrq_pkg::CAPACITY; i++) begin
                seq_reg[i] <= PW'(i);
            end
        end else if (fire) begin
            tail_reg <= tail_next;
            head_reg <= head_next;
            if (clear) begin
                for (int i = 0; i < ssrq_pkg::CAPACITY; i++) begin
                    seq_reg[i] <= PW'(i);
                end
            end else if (seq_we) begin
                seq_reg[addr] <= seq_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

>>> design/ssrq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ssrq_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [ssrq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    ssrq_pkg::result_t res;
    assign res = m_axis_tdata[$bits(ssrq_pkg::result_t)-1:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res.empty_res == (res.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (res.full_res == (res.occupancy == ssrq_pkg::OCC_W'(ssrq_pkg::CAPACITY))))
        else $error("full flag disagrees with occupancy");

    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !res.ok |-> res.slot_out == '0)
        else $error("slot reported on a failed command");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind sequenced_slot_ring_queue ssrq_checker u_ssrq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
